/* sv/pcrl_pkg.sv */
// ----------------------------------------------------------------------------
// pcrl_pkg: shared types and constants of the ramp limited PID unit
// Widths, register indexes, sequencer states and datapath commands.
// ----------------------------------------------------------------------------
package pcrl_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int LimW           = 31;
  localparam int CfgIdxW        = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_PROP  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INTEG = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DERIV = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RAMP  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LIMIT = 3'd4;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // default output limit: 1000.0 saturated to the limit width
  function automatic logic [LimW-1:0] default_limit(input int frac);
    logic [63:0] d;
    d = 64'd1000 << frac;
    if (d > 64'h7FFF_FFFF) return {LimW{1'b1}};
    return d[LimW-1:0];
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_SUM, ST_OUT
  } state_e;

  // sequencer to datapath
  typedef struct packed {
    logic load;      // capture input beat, start multiplies
    logic div_start; // start the derivative division
    logic finish;    // combine terms, update state
    logic clear;     // zero the state
  } dp_cmd_t;

  // datapath to sequencer
  typedef struct packed {
    logic mul_done;
    logic div_done;
  } dp_sts_t;

endpackage

/* sv/pcrl_if.sv */
// ----------------------------------------------------------------------------
// pcrl_if: valid/ready channel interfaces
// Input beat, result beat and configuration write channels.
// ----------------------------------------------------------------------------
interface pcrl_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] error_sample;
  logic [31:0] interval_ms;
  modport source (output valid, command, error_sample, interval_ms, input ready);
  modport sink   (input valid, command, error_sample, interval_ms, output ready);
endinterface

interface pcrl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] drive_value;
  logic        rejected;
  modport source (output valid, drive_value, rejected, input ready);
  modport sink   (input valid, drive_value, rejected, output ready);
endinterface

interface pcrl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/pcrl_div.sv */
// ----------------------------------------------------------------------------
// pcrl_div: restoring divider, one quotient bit per cycle
// Unsigned NUM_W / DEN_W division, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pcrl_div #(
  parameter int NUM_W = 80,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   trial;

  // one shift-subtract step
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

/* sv/pcrl_datapath.sv */
// ----------------------------------------------------------------------------
// pcrl_datapath: PID arithmetic and state registers
// Sequential 32x32 partial products, a divider for the derivative,
// term combine, integral and output clamps, ramp limit.
// ----------------------------------------------------------------------------
module pcrl_datapath #(
  parameter int FRAC_BITS  = pcrl_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = pcrl_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pcrl_pkg::dp_cmd_t       cmd_i,
  output pcrl_pkg::dp_sts_t       sts_o,
  input  logic [31:0]             err_i,
  input  logic [31:0]             dt_i,
  input  logic [31:0]             kp_i,
  input  logic [31:0]             ki_i,
  input  logic [31:0]             kd_i,
  input  logic [pcrl_pkg::LimW-1:0] ramp_i,
  input  logic [pcrl_pkg::LimW-1:0] lim_i,
  output logic [31:0]             drive_o
);
  import pcrl_pkg::*;

  localparam int W = 64;                 // signed working width
  localparam logic [63:0] Cap = 64'd1 << 60;

  logic signed [W-1:0] e_q, last_e_q, integ_q, last_drive_q;
  logic signed [W-1:0] e_in, kp_s, ki_s, kd_s;
  logic signed [W-1:0] p_q, half_q, inc_q, d_q;

  // sign extension at DATA_WIDTH
  function automatic logic signed [W-1:0] sx(input logic [31:0] v);
    logic [W-1:0] t;
    t = W'(v);
    t = t & ((W'(1) << DATA_WIDTH) - 1);
    if (t[DATA_WIDTH-1]) t = t - (W'(1) << DATA_WIDTH);
    return $signed(t);
  endfunction

  function automatic logic [63:0] magf(input logic signed [W-1:0] x);
    return x[W-1] ? 64'(-x) : 64'(x);
  endfunction

  assign e_in = sx(err_i);
  assign kp_s = sx(kp_i);
  assign ki_s = sx(ki_i);
  assign kd_s = sx(kd_i);

  // ---------------- sequential multiplier ----------------
  // 64x64 magnitude product built from four 32x32 partials, one a cycle
  logic [63:0]  ma_q, mb_q;
  logic [127:0] acc_q;
  logic [1:0]   part_q;
  logic         mbusy_q, mneg_q, mdone_q;
  logic [1:0]   job_q;          // 0 p, 1 half, 2 inc, 3 kd*diff
  logic [6:0]   msh_q;
  logic [63:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] ppx;
  logic [127:0] shv;
  logic [63:0]  capped;
  logic signed [W-1:0] sgn_res;
  logic signed [W-1:0] s_sum, diff;
  logic [79:0]  kd_prod_q;
  logic [31:0]  dt_q;
  logic         dneg_q;
  logic         all_done_q;

  // partial weight: 0, 32 or 64 bits up
  assign pa  = part_q[0] ? {32'd0, ma_q[63:32]} : {32'd0, ma_q[31:0]};
  assign pb  = part_q[1] ? {32'd0, mb_q[63:32]} : {32'd0, mb_q[31:0]};
  assign pp  = pa[31:0] * pb[31:0];
  assign ppx = 128'(pp) << {part_q[1] & part_q[0], part_q[1] ^ part_q[0], 5'd0};

  assign shv    = acc_q >> msh_q;
  assign capped = (shv[127:61] != '0 || shv[60:0] > 61'(Cap)) ? Cap : shv[63:0];
  assign sgn_res = mneg_q ? -$signed(capped) : $signed(capped);

  assign s_sum = e_q + last_e_q;
  assign diff  = e_q - last_e_q;

  // launch helper values
  logic        launch;
  logic [63:0] la, lb;
  logic        lneg;
  logic [6:0]  lsh;
  logic [1:0]  ljob;

  always_comb begin
    launch = 1'b0;
    la = '0; lb = '0; lneg = 1'b0; lsh = 7'(FRAC_BITS); ljob = 2'd0;
    if (cmd_i.load) begin
      launch = 1'b1;
      la = magf(kp_s); lb = magf(e_in);
      lneg = kp_s[W-1] ^ e_in[W-1];
    end else if (mdone_q) begin
      case (job_q)
        2'd0: begin
          launch = 1'b1; ljob = 2'd1;
          la = magf(s_sum); lb = {32'd0, dt_q};
          lneg = s_sum[W-1]; lsh = 7'(FRAC_BITS + 1);
        end
        2'd1: begin
          // half term is on sgn_res this cycle
          launch = 1'b1; ljob = 2'd2;
          la = magf(ki_s); lb = magf(sgn_res);
          lneg = ki_s[W-1] ^ sgn_res[W-1];
        end
        2'd2: begin
          launch = 1'b1; ljob = 2'd3;
          la = magf(kd_s); lb = magf(diff);
          lsh = 7'd0;
        end
        default: launch = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q    <= 1'b0;
      mdone_q    <= 1'b0;
      part_q     <= '0;
      job_q      <= '0;
      all_done_q <= 1'b0;
    end else begin
      mdone_q    <= 1'b0;
      // raised once the kd*diff product is registered
      all_done_q <= mdone_q && (job_q == 2'd3);
      if (launch) begin
        mbusy_q <= 1'b1;
        part_q  <= '0;
        job_q   <= ljob;
      end else if (mbusy_q) begin
        part_q <= part_q + 1'b1;
        if (part_q == 2'd3) begin
          mbusy_q <= 1'b0;
          mdone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      e_q  <= e_in;
      dt_q <= dt_i;
    end
    if (launch) begin
      ma_q <= la; mb_q <= lb; mneg_q <= lneg; msh_q <= lsh;
      acc_q <= '0;
    end else if (mbusy_q) begin
      acc_q <= acc_q + ppx;
    end
    if (mdone_q) begin
      case (job_q)
        2'd0: p_q    <= sgn_res;
        2'd1: half_q <= sgn_res;
        2'd2: inc_q  <= sgn_res;
        default: begin
          kd_prod_q <= acc_q[79:0];
          dneg_q    <= kd_s[W-1] ^ diff[W-1];
        end
      endcase
    end
  end

  assign sts_o.mul_done = all_done_q;

  // ---------------- derivative division ----------------
  logic [79:0] quot;
  logic        ddone;
  logic [63:0] dq;

  pcrl_div #(.NUM_W(80), .DEN_W(32)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (kd_prod_q),
    .den_i   (dt_q),
    .done_o  (ddone),
    .quot_o  (quot)
  );

  assign dq = (quot[79:61] != '0 || quot[60:0] > 61'(Cap)) ? Cap : quot[63:0];

  always_ff @(posedge clk_i) begin
    if (ddone) d_q <= dneg_q ? -$signed(dq) : $signed(dq);
  end
  assign sts_o.div_done = ddone;

  // ---------------- combine and state update ----------------
  logic signed [W-1:0] lim, ramp, integ_raw, integ_c, sum, drv, dlt;

  assign lim  = W'(lim_i);
  assign ramp = W'(ramp_i);

  always_comb begin
    integ_raw = integ_q + inc_q;
    integ_c   = integ_raw > lim ? lim : (integ_raw < -lim ? -lim : integ_raw);
    sum       = p_q + integ_c + d_q;
    drv       = sum > lim ? lim : (sum < -lim ? -lim : sum);
    dlt       = drv - last_drive_q;
    if (ramp != 0) begin
      if (dlt > ramp) drv = last_drive_q + ramp;
      else if (dlt < -ramp) drv = last_drive_q - ramp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_e_q     <= '0;
      integ_q      <= '0;
      last_drive_q <= '0;
    end else if (cmd_i.clear) begin
      last_e_q     <= '0;
      integ_q      <= '0;
      last_drive_q <= '0;
    end else if (cmd_i.finish) begin
      last_e_q     <= e_q;
      integ_q      <= integ_c;
      last_drive_q <= drv;
    end
  end

  assign drive_o = drv[31:0];
endmodule

/* sv/pcrl_ctrl.sv */
// ----------------------------------------------------------------------------
// pcrl_ctrl: sequencer of the PID unit
// Takes input beats, steps the datapath, holds the result beat.
// ----------------------------------------------------------------------------
module pcrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [31:0]       interval_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              rejected_o,
  output logic              take_drive_o,
  output pcrl_pkg::dp_cmd_t cmd_o,
  input  pcrl_pkg::dp_sts_t sts_i
);
  import pcrl_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d, rej_q, rej_d;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q;
    rej_d   = rej_q;
    cmd_o   = '0;
    take_drive_o = 1'b0;
    in_ready_o   = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !ov_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          if (command_i == CMD_CLEAR) begin
            cmd_o.clear = 1'b1;
          end else if (interval_i == '0) begin
            ov_d = 1'b1; rej_d = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: if (sts_i.mul_done) begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: if (sts_i.div_done) state_d = ST_SUM;
      ST_SUM: if (!ov_q || out_ready_i) begin
        cmd_o.finish = 1'b1;
        take_drive_o = 1'b1;
        ov_d = 1'b1; rej_d = 1'b0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      rej_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      rej_q   <= rej_d;
    end
  end

  assign out_valid_o = ov_q;
  assign rejected_o  = rej_q;

  // only idle takes beats
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  // finishing always raises a result
  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> ov_q) else $error("finish without result");
  // a load leads into the multiply phase
  a_load_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_MUL) else $error("load lost");
endmodule

/* sv/pid_controller_ramp_limited_unit.sv */
// ----------------------------------------------------------------------------
// pid_controller_ramp_limited_unit: Q16.16 PID regulator with ramp limit
// Trapezoidal integral, derivative by division, output clamp and slew limit.
// ----------------------------------------------------------------------------
// Sequence: from the accepting edge to a valid result, the unit runs four
// multiplies, then an 80-step restoring division of kd*diff.
// Throughput: one update at a time; a clear or rejected beat is handled in
// the idle state without starting the multiplies.
// Reset clears integral, last error, last drive, gains and ramp; output limit resets to 1000.0.
module pid_controller_ramp_limited_unit #(
  parameter int FRAC_BITS  = pcrl_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = pcrl_pkg::DATA_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  pcrl_in_if.sink    in_i,
  pcrl_out_if.source out_o,
  pcrl_cfg_if.sink   cfg_i
);
  import pcrl_pkg::*;

  logic [31:0]     kp_q, ki_q, kd_q;
  logic [LimW-1:0] ramp_q, lim_q;
  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic            take, rej;
  logic [31:0]     drv, drv_q;

  // configuration writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0; ki_q <= '0; kd_q <= '0; ramp_q <= '0;
      lim_q <= default_limit(FRAC_BITS);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PROP:  kp_q <= cfg_i.data;
        REG_INTEG: ki_q <= cfg_i.data;
        REG_DERIV: kd_q <= cfg_i.data;
        REG_RAMP:  ramp_q <= cfg_i.data[LimW-1:0];
        REG_LIMIT: lim_q <= (cfg_i.data[LimW-1:0] == '0) ?
                            default_limit(FRAC_BITS) : cfg_i.data[LimW-1:0];
        default: ;
      endcase
    end
  end

  pcrl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .command_i   (in_i.command),
    .interval_i  (in_i.interval_ms),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .rejected_o  (rej),
    .take_drive_o(take),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pcrl_datapath #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .sts_o  (sts),
    .err_i  (in_i.error_sample),
    .dt_i   (in_i.interval_ms),
    .kp_i   (kp_q), .ki_i (ki_q), .kd_i (kd_q),
    .ramp_i (ramp_q), .lim_i (lim_q),
    .drive_o(drv)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (take) drv_q <= drv;
  end

  assign out_o.drive_value = rej ? 32'd0 : drv_q;
  assign out_o.rejected    = rej;
endmodule
